// ===== hw/rtl/jcasl_pkg.sv =====
// Package: shared types and codes for the jog command arbiter.
package jcasl_pkg;

    localparam int COORD_W  = 24;
    localparam int HANDLE_W = 8;
    localparam int REG_W    = 20;
    localparam int ACC_W    = 21;
    localparam int SQ_W     = 44;
    localparam int ROOT_W   = 22;
    localparam int PROD_W   = ACC_W + REG_W;

    typedef enum logic [2:0] {
        MODE_JOG      = 3'd0,
        MODE_POSITION = 3'd1,
        MODE_POSE     = 3'd2,
        MODE_NAMED    = 3'd3,
        MODE_CLEAR    = 3'd4,
        MODE_FETCH    = 3'd5,
        MODE_RSVD6    = 3'd6,
        MODE_RSVD7    = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_JOG      = 3'd1,
        KIND_POSITION = 3'd2,
        KIND_POSE     = 3'd3,
        KIND_NAMED    = 3'd4
    } t_kind;

    localparam logic REG_STEP_LIM    = 1'b0;
    localparam logic REG_MAX_PENDING = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]                 mode;
        logic signed [COORD_W-1:0]  in_x;
        logic signed [COORD_W-1:0]  in_y;
        logic signed [COORD_W-1:0]  in_z;
        logic [HANDLE_W-1:0]        target_handle;
    } t_in_word;

    typedef struct packed {
        logic [2:0]                 cmd_kind;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_z;
        logic [HANDLE_W-1:0]        out_handle;
        logic                       still_pending;
    } t_out_word;

endpackage

// ===== hw/rtl/jog_command_arbiter_step_limiter.sv =====
// Jog command arbiter with step limiter: top level.
// A jog, target, clear, unused-mode or non-jog fetch word has its result valid in the cycle
// after acceptance. A fetch of a jog step computes its result by three squarings on the
// shared 21x21 multiplier, 22 square-root iterations and one compare when the step fits the
// step limit; when it must be cut, three multiplies and three 41-step restoring divisions
// are added, one quotient bit per cycle. Input ready is low from acceptance until the result
// word is taken.
// Configuration: index 0 longest jog step, index 1 per-axis jog clamp, both in micrometers.
module jog_command_arbiter_step_limiter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  jcasl_pkg::t_in_word   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output jcasl_pkg::t_out_word  o_data,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [19:0]           i_cfg_data
);
    import jcasl_pkg::*;

    t_state r_state, n_state;
    logic [REG_W-1:0] r_step_lim, r_max_pend;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [COORD_W-1:0] r_pos [3];
    logic [HANDLE_W-1:0] r_pose_h, r_named_h;
    logic [2:0] r_flags;
    t_out_word r_out;
    logic r_ovalid;

    logic [1:0] r_ax;
    logic [SQ_W-1:0] r_sq, r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [5:0] r_cnt;
    logic [PROD_W-1:0] r_prod, r_quo;
    logic [PROD_W:0] r_drem;
    logic r_neg;
    logic signed [COORD_W-1:0] r_step [3];

    logic accept, acc_nz;
    logic signed [ACC_W-1:0] cur_a;
    logic [ACC_W-1:0] abs_a;
    logic [2*ACC_W-1:0] mul_out;
    logic [SQ_W-1:0] trial;
    logic [PROD_W:0] dshift;
    logic [PROD_W:0] dsub;
    logic signed [COORD_W:0] sum [3];
    logic signed [COORD_W:0] lim;
    t_out_word idle_out;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign acc_nz = (r_acc[0] != '0) || (r_acc[1] != '0) || (r_acc[2] != '0);
    assign cur_a = r_acc[r_ax];
    assign abs_a = cur_a[ACC_W-1] ? ACC_W'(-cur_a) : ACC_W'(cur_a);

    // shared multiplier
    always_comb begin
        if (r_state == ST_SQUARE) begin
            mul_out = abs_a * abs_a;
        end else begin
            mul_out = abs_a * {{(ACC_W-REG_W){1'b0}}, r_step_lim};
        end
    end

    assign trial = SQ_W'({r_root, 2'b01}) << (2 * r_cnt);
    assign dshift = {r_drem[PROD_W-1:0], r_prod[PROD_W-1]};
    assign dsub = dshift - {{(PROD_W+1-ROOT_W){1'b0}}, r_root};
    assign lim = (COORD_W+1)'(r_max_pend);

    always_comb begin
        sum[0] = (COORD_W+1)'(r_acc[0]) + (COORD_W+1)'(i_data.in_x);
        sum[1] = (COORD_W+1)'(r_acc[1]) + (COORD_W+1)'(i_data.in_y);
        sum[2] = (COORD_W+1)'(r_acc[2]) + (COORD_W+1)'(i_data.in_z);
    end

    always_comb begin
        idle_out = '0;
        case (t_mode'(i_data.mode)) inside
            MODE_JOG: begin
                idle_out.still_pending =
                    (sum[0] != 0 && lim != 0) || (sum[1] != 0 && lim != 0)
                    || (sum[2] != 0 && lim != 0);
            end
            MODE_POSITION, MODE_POSE, MODE_NAMED: idle_out.still_pending = 1'b1;
            MODE_CLEAR: ;
            MODE_FETCH: begin
                if (r_flags[2]) begin
                    idle_out.cmd_kind = KIND_NAMED;
                    idle_out.out_handle = r_named_h;
                    idle_out.still_pending = r_flags[1] || r_flags[0] || acc_nz;
                end else if (r_flags[1]) begin
                    idle_out.cmd_kind = KIND_POSE;
                    idle_out.out_handle = r_pose_h;
                    idle_out.still_pending = r_flags[0] || acc_nz;
                end else if (r_flags[0]) begin
                    idle_out.cmd_kind = KIND_POSITION;
                    idle_out.out_x = r_pos[0];
                    idle_out.out_y = r_pos[1];
                    idle_out.out_z = r_pos[2];
                    idle_out.still_pending = acc_nz;
                end
            end
            default: idle_out.still_pending = (r_flags != 0) || acc_nz;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && t_mode'(i_data.mode) == MODE_FETCH && r_flags == 3'b000
                    && acc_nz) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: if (r_ax == 2'd2) n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_cnt == 6'd0) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_root <= ROOT_W'(r_step_lim)) n_state = ST_OUT;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 6'd0) n_state = (r_ax == 2'd2) ? ST_OUT : ST_MUL;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step_lim <= REG_W'(5000);
            r_max_pend <= REG_W'(30000);
            r_flags    <= '0;
            r_ovalid   <= 1'b0;
            r_pose_h   <= '0;
            r_named_h  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
                r_pos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_STEP_LIM) r_step_lim <= i_cfg_data;
                else r_max_pend <= i_cfg_data;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_out <= idle_out;
                        r_ax  <= 2'd0;
                        r_sq  <= '0;
                        case (t_mode'(i_data.mode))
                            MODE_JOG: begin
                                r_flags <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    if (sum[i] > lim) r_acc[i] <= ACC_W'(lim);
                                    else if (sum[i] < -lim) r_acc[i] <= ACC_W'(-lim);
                                    else r_acc[i] <= ACC_W'(sum[i]);
                                end
                                r_ovalid <= 1'b1;
                            end
                            MODE_POSITION: begin
                                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                                r_pos[0] <= i_data.in_x;
                                r_pos[1] <= i_data.in_y;
                                r_pos[2] <= i_data.in_z;
                                r_flags <= 3'b001;
                                r_ovalid <= 1'b1;
                            end
                            MODE_POSE: begin
                                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                                r_pose_h <= i_data.target_handle;
                                r_flags <= 3'b010;
                                r_ovalid <= 1'b1;
                            end
                            MODE_NAMED: begin
                                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                                r_named_h <= i_data.target_handle;
                                r_flags <= 3'b100;
                                r_ovalid <= 1'b1;
                            end
                            MODE_CLEAR: begin
                                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                                r_flags <= '0;
                                r_ovalid <= 1'b1;
                            end
                            MODE_FETCH: begin
                                if (r_flags[2]) begin
                                    r_flags[2] <= 1'b0;
                                    r_ovalid <= 1'b1;
                                end else if (r_flags[1]) begin
                                    r_flags[1] <= 1'b0;
                                    r_ovalid <= 1'b1;
                                end else if (r_flags[0]) begin
                                    r_flags[0] <= 1'b0;
                                    r_ovalid <= 1'b1;
                                end else if (!acc_nz) begin
                                    r_ovalid <= 1'b1;
                                end
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SQUARE: begin
                    r_sq <= r_sq + SQ_W'(mul_out);
                    if (r_ax == 2'd2) begin
                        r_rem  <= r_sq + SQ_W'(mul_out);
                        r_root <= '0;
                        r_cnt  <= 6'(ROOT_W - 1);
                        r_ax   <= 2'd0;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                ST_ROOT: begin
                    // one bit of the root per cycle
                    if (r_rem >= trial) begin
                        r_rem  <= r_rem - trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
                end
                ST_MUL: begin
                    r_prod <= PROD_W'(mul_out);
                    r_neg  <= cur_a[ACC_W-1];
                    r_drem <= '0;
                    r_quo  <= '0;
                    r_cnt  <= 6'(PROD_W - 1);
                    if (r_root <= ROOT_W'(r_step_lim)) begin
                        for (int i = 0; i < 3; i++) r_step[i] <= COORD_W'(r_acc[i]);
                    end
                end
                ST_DIV: begin
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                    if (!dsub[PROD_W]) begin
                        r_drem <= dsub;
                        r_quo  <= {r_quo[PROD_W-2:0], 1'b1};
                    end else begin
                        r_drem <= dshift;
                        r_quo  <= {r_quo[PROD_W-2:0], 1'b0};
                    end
                    if (r_cnt != 6'd0) begin
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_step[r_ax] <= r_neg
                            ? -COORD_W'({r_quo[PROD_W-2:0], !dsub[PROD_W]})
                            :  COORD_W'({r_quo[PROD_W-2:0], !dsub[PROD_W]});
                        r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    end
                end
                ST_OUT: begin
                    r_out <= '{cmd_kind: KIND_JOG, out_x: r_step[0], out_y: r_step[1],
                               out_z: r_step[2], out_handle: '0,
                               still_pending: (r_acc[0] != ACC_W'(r_step[0]))
                                   || (r_acc[1] != ACC_W'(r_step[1]))
                                   || (r_acc[2] != ACC_W'(r_step[2]))};
                    for (int i = 0; i < 3; i++) begin
                        r_acc[i] <= r_acc[i] - ACC_W'(r_step[i]);
                    end
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == ST_IDLE)
        else $error("result while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_flags))
        else $error("more than one target pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word dropped or changed while waiting");

endmodule
